### rtl/core/rav_pkg.sv
// ----------------------------------------------------------------------------
// RIFF archive validator package
// Shared types, codes, tag constants and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rav_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int CSR_WIDTH           = 32;
   localparam int STATUS_WIDTH        = 4;
   localparam int COUNT_WIDTH         = 28;
   localparam int SIZE_WIDTH          = 32;
   localparam int MIN_LENGTH          = 12;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [31:0] TAG_RIFF = "RIFF";
   localparam logic [31:0] TAG_FORM = "HH2 ";
   localparam logic [31:0] TAG_LIST = "LIST";
   localparam logic [31:0] TAG_PATH = "path";
   localparam logic [31:0] TAG_DATA = "data";

   typedef enum logic [3:0] {
      PH_RIFF_ID   = 4'd0,
      PH_RIFF_SIZE = 4'd1,
      PH_FORM      = 4'd2,
      PH_LIST_ID   = 4'd3,
      PH_LIST_SIZE = 4'd4,
      PH_PATH_ID   = 4'd5,
      PH_PATH_SIZE = 4'd6,
      PH_PATH_BODY = 4'd7,
      PH_PATH_PAD  = 4'd8,
      PH_DATA_ID   = 4'd9,
      PH_DATA_SIZE = 4'd10,
      PH_LIST_REST = 4'd11,
      PH_LIST_PAD  = 4'd12,
      PH_HALT      = 4'd13,
      PH_IDLE      = 4'd14
   } phase_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK         = 4'd0,
      ST_SHORT      = 4'd1,
      ST_RIFF_ID    = 4'd2,
      ST_RIFF_SIZE  = 4'd3,
      ST_FORM       = 4'd4,
      ST_LIST_ID    = 4'd5,
      ST_LIST_SIZE  = 4'd6,
      ST_PATH_ID    = 4'd7,
      ST_PATH_SIZE  = 4'd8,
      ST_NO_NUL     = 4'd9,
      ST_DATA_ID    = 4'd10,
      ST_DATA_SIZE  = 4'd11,
      ST_INCOMPLETE = 4'd12,
      ST_EMPTY      = 4'd13
   } status_type;

   typedef struct packed {
      logic       start_req;
      logic [7:0] byte_in;
   } item_type;

   typedef struct packed {
      status_type             status;
      logic [COUNT_WIDTH-1:0] entry_count;
   } result_type;

   // The first error sticks; later errors only halt the parse.
   function automatic status_type keep_error(status_type current, status_type code);
      keep_error = (current == ST_OK) ? code : current;
   endfunction

   function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0:    value = tag[31:24];
         2'd1:    value = tag[23:16];
         2'd2:    value = tag[15:8];
         default: value = tag[7:0];
      endcase
      tag_byte = value;
   endfunction

   function automatic logic [31:0] tag_of(phase_type phase);
      logic [31:0] value;
      unique case (phase)
         PH_RIFF_ID: value = TAG_RIFF;
         PH_FORM:    value = TAG_FORM;
         PH_LIST_ID: value = TAG_LIST;
         PH_PATH_ID: value = TAG_PATH;
         default:    value = TAG_DATA;
      endcase
      tag_of = value;
   endfunction

   function automatic status_type tag_error(phase_type phase);
      status_type value;
      unique case (phase)
         PH_RIFF_ID: value = ST_RIFF_ID;
         PH_FORM:    value = ST_FORM;
         PH_LIST_ID: value = ST_LIST_ID;
         PH_PATH_ID: value = ST_PATH_ID;
         default:    value = ST_DATA_ID;
      endcase
      tag_error = value;
   endfunction

   function automatic phase_type tag_next(phase_type phase);
      phase_type value;
      unique case (phase)
         PH_RIFF_ID: value = PH_RIFF_SIZE;
         PH_FORM:    value = PH_LIST_ID;
         PH_LIST_ID: value = PH_LIST_SIZE;
         PH_PATH_ID: value = PH_PATH_SIZE;
         default:    value = PH_DATA_SIZE;
      endcase
      tag_next = value;
   endfunction

endpackage

`default_nettype wire

### rtl/core/rav_req_if.sv
// ----------------------------------------------------------------------------
// RIFF archive validator request channel
// Valid/ready channel that carries one archive byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rav_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [7:0] byte_in;

   modport source (output valid, output start_req, output byte_in, input ready);
   modport sink (input valid, input start_req, input byte_in, output ready);
endinterface

`default_nettype wire

### rtl/core/rav_rsp_if.sv
// ----------------------------------------------------------------------------
// RIFF archive validator response channel
// Valid/ready channel that carries the final status and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rav_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rav_pkg::STATUS_WIDTH-1:0] status;
   logic [rav_pkg::COUNT_WIDTH-1:0]  entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/core/rav_in_stage.sv
// ----------------------------------------------------------------------------
// RIFF archive validator input stage
// Registers one request and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rav_in_stage (
   input  wire logic          clock,
   input  wire logic          reset,
   rav_req_if.sink            req_bus,
   input  wire logic          item_take,
   output logic               item_valid,
   output rav_pkg::item_type  item
);

   logic              valid_ff;
   rav_pkg::item_type item_ff;

   assign req_bus.ready = !valid_ff || item_take;
   assign item_valid    = valid_ff;
   assign item          = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         item_ff.start_req <= req_bus.start_req;
         item_ff.byte_in   <= req_bus.byte_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/rav_parser.sv
// ----------------------------------------------------------------------------
// RIFF archive validator parser
// Holds the parse state; it advances a byte per cycle unless a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module rav_parser #(
   parameter int LENGTH_BITS = rav_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [rav_pkg::CSR_WIDTH-1:0] csr_write_data,
   input  wire logic                          item_valid,
   input  rav_pkg::item_type                  item,
   output logic                               item_take,
   input  wire logic                          out_free,
   output logic                               result_load,
   output rav_pkg::result_type                result
);

   logic [rav_pkg::CSR_WIDTH-1:0]   total_length_ff;
   rav_pkg::phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]          pos_ff, pos_in;
   logic [1:0]                      fbi_ff, fbi_in;
   logic [rav_pkg::SIZE_WIDTH-1:0]  acc_ff, acc_in;
   logic [rav_pkg::SIZE_WIDTH-1:0]  list_ff, list_in;
   logic [rav_pkg::SIZE_WIDTH-1:0]  chunk_ff, chunk_in;
   logic [7:0]                      last_ff, last_in;
   rav_pkg::status_type             error_ff, error_in;
   logic [rav_pkg::COUNT_WIDTH-1:0] entries_ff, entries_in;

   logic [LENGTH_BITS-1:0] total;
   logic [LENGTH_BITS-1:0] last_pos;
   logic [LENGTH_BITS-1:0] pos;
   logic [LENGTH_BITS-1:0] rem_after;
   logic                   has_result;
   logic                   size_done;
   logic [7:0]             b;

   assign b           = item.byte_in;
   assign item_take   = item_valid && (!has_result || out_free);
   assign result_load = item_valid && has_result && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff <= rav_pkg::CSR_WIDTH'(1);
      end else if (csr_write_enable) begin
         total_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rav_pkg::PH_RIFF_ID;
         pos_ff     <= '0;
         fbi_ff     <= '0;
         acc_ff     <= '0;
         list_ff    <= '0;
         chunk_ff   <= '0;
         last_ff    <= '0;
         error_ff   <= rav_pkg::ST_OK;
         entries_ff <= '0;
      end else if (item_take) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         fbi_ff     <= fbi_in;
         acc_ff     <= acc_in;
         list_ff    <= list_in;
         chunk_ff   <= chunk_in;
         last_ff    <= last_in;
         error_ff   <= error_in;
         entries_ff <= entries_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      fbi_in     = fbi_ff;
      acc_in     = acc_ff;
      list_in    = list_ff;
      chunk_in   = chunk_ff;
      last_in    = last_ff;
      error_in   = error_ff;
      entries_in = entries_ff;
      has_result = 1'b0;
      size_done  = 1'b0;
      result     = '{status: rav_pkg::ST_OK, entry_count: '0};

      if (item.start_req) begin
         phase_in   = rav_pkg::PH_RIFF_ID;
         pos_in     = '0;
         fbi_in     = '0;
         acc_in     = '0;
         list_in    = '0;
         chunk_in   = '0;
         last_in    = '0;
         error_in   = rav_pkg::ST_OK;
         entries_in = '0;
      end

      total     = total_length_ff[LENGTH_BITS-1:0];
      last_pos  = total - LENGTH_BITS'(1);
      pos       = pos_in;
      rem_after = last_pos - pos;

      if (phase_in != rav_pkg::PH_IDLE) begin
         if (pos == '0 && total < LENGTH_BITS'(rav_pkg::MIN_LENGTH)) begin
            error_in = rav_pkg::keep_error(error_in, rav_pkg::ST_SHORT);
            phase_in = rav_pkg::PH_HALT;
         end

         if (phase_in >= rav_pkg::PH_PATH_ID && phase_in <= rav_pkg::PH_LIST_REST
             && list_in != '0) begin
            list_in = list_in - rav_pkg::SIZE_WIDTH'(1);
         end

         if (phase_in == rav_pkg::PH_RIFF_SIZE || phase_in == rav_pkg::PH_LIST_SIZE
             || phase_in == rav_pkg::PH_PATH_SIZE || phase_in == rav_pkg::PH_DATA_SIZE) begin
            acc_in    = acc_in | (rav_pkg::SIZE_WIDTH'(b) << {fbi_in, 3'b000});
            size_done = (fbi_in == 2'd3);
            fbi_in    = fbi_in + 2'd1;
         end

         unique case (phase_in)
            rav_pkg::PH_RIFF_ID, rav_pkg::PH_FORM, rav_pkg::PH_LIST_ID,
            rav_pkg::PH_PATH_ID, rav_pkg::PH_DATA_ID: begin
               if (b != rav_pkg::tag_byte(rav_pkg::tag_of(phase_in), fbi_in)) begin
                  error_in = rav_pkg::keep_error(error_in, rav_pkg::tag_error(phase_in));
                  phase_in = rav_pkg::PH_HALT;
               end else begin
                  if (fbi_in == 2'd3) begin
                     acc_in   = '0;
                     phase_in = rav_pkg::tag_next(phase_in);
                  end
                  fbi_in = fbi_in + 2'd1;
               end
            end
            rav_pkg::PH_RIFF_SIZE: begin
               if (size_done) begin
                  if (acc_in > rav_pkg::SIZE_WIDTH'(rem_after)) begin
                     error_in = rav_pkg::keep_error(error_in, rav_pkg::ST_RIFF_SIZE);
                     phase_in = rav_pkg::PH_HALT;
                  end else begin
                     phase_in = rav_pkg::PH_FORM;
                  end
               end
            end
            rav_pkg::PH_LIST_SIZE: begin
               if (size_done) begin
                  if (acc_in > rav_pkg::SIZE_WIDTH'(rem_after)) begin
                     error_in = rav_pkg::keep_error(error_in, rav_pkg::ST_LIST_SIZE);
                     phase_in = rav_pkg::PH_HALT;
                  end else begin
                     list_in  = acc_in;
                     phase_in = rav_pkg::PH_PATH_ID;
                  end
               end
            end
            rav_pkg::PH_PATH_SIZE: begin
               if (size_done) begin
                  if (acc_in == '0 || acc_in > list_in) begin
                     error_in = rav_pkg::keep_error(error_in, rav_pkg::ST_PATH_SIZE);
                     phase_in = rav_pkg::PH_HALT;
                  end else begin
                     chunk_in = acc_in;
                     phase_in = rav_pkg::PH_PATH_BODY;
                  end
               end
            end
            rav_pkg::PH_PATH_BODY: begin
               last_in = b;
               if (chunk_in != '0) begin
                  chunk_in = chunk_in - rav_pkg::SIZE_WIDTH'(1);
               end
               if (chunk_in == '0) begin
                  if (b != 8'd0) begin
                     error_in = rav_pkg::keep_error(error_in, rav_pkg::ST_NO_NUL);
                     phase_in = rav_pkg::PH_HALT;
                  end else begin
                     phase_in = pos[0] ? rav_pkg::PH_DATA_ID : rav_pkg::PH_PATH_PAD;
                  end
               end
            end
            rav_pkg::PH_PATH_PAD: begin
               phase_in = rav_pkg::PH_DATA_ID;
            end
            rav_pkg::PH_DATA_SIZE: begin
               if (size_done) begin
                  if (acc_in > list_in) begin
                     error_in = rav_pkg::keep_error(error_in, rav_pkg::ST_DATA_SIZE);
                     phase_in = rav_pkg::PH_HALT;
                  end else if (list_in == '0) begin
                     if (entries_in != rav_pkg::COUNT_MAX) begin
                        entries_in = entries_in + rav_pkg::COUNT_WIDTH'(1);
                     end
                     phase_in = pos[0] ? rav_pkg::PH_LIST_ID : rav_pkg::PH_LIST_PAD;
                  end else begin
                     phase_in = rav_pkg::PH_LIST_REST;
                  end
               end
            end
            rav_pkg::PH_LIST_REST: begin
               if (list_in == '0) begin
                  if (entries_in != rav_pkg::COUNT_MAX) begin
                     entries_in = entries_in + rav_pkg::COUNT_WIDTH'(1);
                  end
                  phase_in = pos[0] ? rav_pkg::PH_LIST_ID : rav_pkg::PH_LIST_PAD;
               end
            end
            rav_pkg::PH_LIST_PAD: begin
               phase_in = rav_pkg::PH_LIST_ID;
            end
            default: begin
            end
         endcase

         if (phase_in >= rav_pkg::PH_PATH_ID && phase_in <= rav_pkg::PH_DATA_SIZE
             && list_in == '0) begin
            error_in = rav_pkg::keep_error(error_in, rav_pkg::ST_LIST_SIZE);
            phase_in = rav_pkg::PH_HALT;
         end

         if (pos == last_pos) begin
            has_result         = 1'b1;
            result.entry_count = entries_in;
            if (error_in != rav_pkg::ST_OK) begin
               result.status = error_in;
            end else if (phase_in == rav_pkg::PH_LIST_ID && fbi_in == 2'd0) begin
               result.status = (entries_in != '0) ? rav_pkg::ST_OK : rav_pkg::ST_EMPTY;
            end else begin
               result.status = rav_pkg::ST_INCOMPLETE;
            end
            phase_in = rav_pkg::PH_IDLE;
         end else begin
            pos_in = pos + LENGTH_BITS'(1);
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/rav_out_stage.sv
// ----------------------------------------------------------------------------
// RIFF archive validator output stage
// Result register that holds a response until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rav_out_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            result_load,
   input  rav_pkg::result_type  result,
   output logic                 out_free,
   rav_rsp_if.source            rsp_bus
);

   logic                valid_ff;
   rav_pkg::result_type result_ff;

   assign out_free            = !valid_ff || rsp_bus.ready;
   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.status      = result_ff.status;
   assign rsp_bus.entry_count = result_ff.entry_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         result_ff <= result;
      end
   end

endmodule

`default_nettype wire

### rtl/core/riff_archive_validator.sv
// ----------------------------------------------------------------------------
// RIFF archive validator
// Checks a streamed RIFF archive of LIST/path/data entries byte by byte.
// ----------------------------------------------------------------------------
// Each request on req_bus carries one archive byte; start_req marks the first
// byte of a new buffer and restarts the parse. The user must write the buffer
// length through csr_write_enable and csr_write_data only while the block is
// idle; the block does not enforce this. At the last byte of the buffer one
// response leaves on rsp_bus with the status code and the number of complete
// entries; other bytes give none. Bytes after the last one are dropped until
// the next start_req. A request is parsed from an input register and its
// response goes into an output register. The block takes one byte per cycle
// unless a response is held back; the parse state is updated once per byte
// by a single pass of compare and counter logic.
// Reset clears the parse state and sets the buffer length to one; a byte that
// arrives with no start_req after reset begins a new buffer.
// While a response waits for rsp_bus.ready, bytes keep flowing; only a byte
// that would produce a second response waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_archive_validator #(
   parameter int LENGTH_BITS = rav_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   rav_req_if.sink                            req_bus,
   rav_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_write_enable,
   input  wire logic [rav_pkg::CSR_WIDTH-1:0] csr_write_data
);

   logic                item_valid;
   logic                item_take;
   rav_pkg::item_type   item;
   logic                out_free;
   logic                result_load;
   rav_pkg::result_type result;

   rav_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   rav_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .out_free         (out_free),
      .result_load      (result_load),
      .result           (result)
   );

   rav_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_free    (out_free),
      .rsp_bus     (rsp_bus)
   );

   // A clean finish is only reported when at least one entry was found.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == rav_pkg::ST_OK |-> rsp_bus.entry_count != '0)
      else $error("ok status reported with no entries");

   // Status codes never exceed the last defined code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.status <= rav_pkg::ST_EMPTY)
      else $error("undefined status code on response");

   // A held request stays in the input register unchanged.
   assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_take |=> item_valid && $stable(item))
      else $error("held request lost or changed");

   // A response is loaded only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      result_load |-> out_free && item_take)
      else $error("response loaded into a busy output register");

endmodule

`default_nettype wire

### tb/riff_archive_validator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF archive validator testbench
// Streams archive buffers into the validator, one byte per request: directed
// buffers for the short, empty, error, length-change and restart cases, then
// randomly built archives with corrupted fields, truncation and extra bytes.
// A scoreboard tracks the parse of every accepted byte and checks each
// response against the status and entry count it works out.
// ----------------------------------------------------------------------------

module riff_archive_validator_test;

   class archive_scoreboard;
      logic [31:0] buffer_length;
      rav_pkg::phase_type phase;
      logic [31:0] position;
      logic [2:0] field_index;
      logic [31:0] size_acc;
      logic [31:0] list_left;
      logic [31:0] chunk_left;
      logic [7:0] last_path;
      rav_pkg::status_type first_error;
      logic [rav_pkg::COUNT_WIDTH-1:0] entries_done;
      rav_pkg::result_type verdicts[$];
      int mismatches;

      function new();
         buffer_length = 32'd1;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase = rav_pkg::PH_RIFF_ID;
         position = '0;
         field_index = '0;
         size_acc = '0;
         list_left = '0;
         chunk_left = '0;
         last_path = '0;
         first_error = rav_pkg::ST_OK;
         entries_done = '0;
      endfunction

      function void set_length(logic [31:0] value);
         buffer_length = value;
      endfunction

      function void halt(rav_pkg::status_type code);
         if (first_error == rav_pkg::ST_OK) begin
            first_error = code;
         end
         phase = rav_pkg::PH_HALT;
      endfunction

      function void match_tag(logic [31:0] tag, logic [7:0] value,
                              rav_pkg::status_type code,
                              rav_pkg::phase_type next_phase);
         int idx;
         idx = int'(field_index[1:0]);
         if (value != tag[31 - 8 * idx -: 8]) begin
            halt(code);
            return;
         end
         field_index = field_index + 3'd1;
         if (field_index >= 3'd4) begin
            field_index = '0;
            size_acc = '0;
            phase = next_phase;
         end
      endfunction

      function bit gather(logic [7:0] value);
         size_acc = size_acc | ({24'd0, value} << (8 * field_index[1:0]));
         field_index = field_index + 3'd1;
         if (field_index >= 3'd4) begin
            field_index = '0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void close_entry(logic [31:0] pos);
         if (entries_done != rav_pkg::COUNT_MAX) begin
            entries_done = entries_done + rav_pkg::COUNT_WIDTH'(1);
         end
         phase = pos[0] ? rav_pkg::PH_LIST_ID : rav_pkg::PH_LIST_PAD;
      endfunction

      function bit take_byte(logic start, logic [7:0] value,
                             output rav_pkg::result_type verdict);
         logic [31:0] last_pos;
         logic [31:0] pos;
         logic [31:0] rem_after;
         verdict = '0;
         if (start) begin
            restart();
         end
         if (phase == rav_pkg::PH_IDLE) begin
            return 1'b0;
         end
         last_pos = buffer_length - 32'd1;
         pos = position;
         rem_after = last_pos - pos;
         if (pos == 0 && buffer_length < rav_pkg::MIN_LENGTH) begin
            halt(rav_pkg::ST_SHORT);
         end
         if (phase >= rav_pkg::PH_PATH_ID && phase <= rav_pkg::PH_LIST_REST
             && list_left != 0) begin
            list_left = list_left - 32'd1;
         end
         case (phase)
            rav_pkg::PH_RIFF_ID: begin
               match_tag(rav_pkg::TAG_RIFF, value, rav_pkg::ST_RIFF_ID,
                         rav_pkg::PH_RIFF_SIZE);
            end
            rav_pkg::PH_RIFF_SIZE: begin
               if (gather(value)) begin
                  if (size_acc > rem_after) halt(rav_pkg::ST_RIFF_SIZE);
                  else phase = rav_pkg::PH_FORM;
               end
            end
            rav_pkg::PH_FORM: begin
               match_tag(rav_pkg::TAG_FORM, value, rav_pkg::ST_FORM, rav_pkg::PH_LIST_ID);
            end
            rav_pkg::PH_LIST_ID: begin
               match_tag(rav_pkg::TAG_LIST, value, rav_pkg::ST_LIST_ID,
                         rav_pkg::PH_LIST_SIZE);
            end
            rav_pkg::PH_LIST_SIZE: begin
               if (gather(value)) begin
                  if (size_acc > rem_after) begin
                     halt(rav_pkg::ST_LIST_SIZE);
                  end else begin
                     list_left = size_acc;
                     phase = rav_pkg::PH_PATH_ID;
                  end
               end
            end
            rav_pkg::PH_PATH_ID: begin
               match_tag(rav_pkg::TAG_PATH, value, rav_pkg::ST_PATH_ID,
                         rav_pkg::PH_PATH_SIZE);
            end
            rav_pkg::PH_PATH_SIZE: begin
               if (gather(value)) begin
                  if (size_acc == 0 || size_acc > list_left) begin
                     halt(rav_pkg::ST_PATH_SIZE);
                  end else begin
                     chunk_left = size_acc;
                     phase = rav_pkg::PH_PATH_BODY;
                  end
               end
            end
            rav_pkg::PH_PATH_BODY: begin
               last_path = value;
               if (chunk_left != 0) begin
                  chunk_left = chunk_left - 32'd1;
               end
               if (chunk_left == 0) begin
                  if (last_path != 8'd0) halt(rav_pkg::ST_NO_NUL);
                  else phase = pos[0] ? rav_pkg::PH_DATA_ID : rav_pkg::PH_PATH_PAD;
               end
            end
            rav_pkg::PH_PATH_PAD: begin
               phase = rav_pkg::PH_DATA_ID;
            end
            rav_pkg::PH_DATA_ID: begin
               match_tag(rav_pkg::TAG_DATA, value, rav_pkg::ST_DATA_ID,
                         rav_pkg::PH_DATA_SIZE);
            end
            rav_pkg::PH_DATA_SIZE: begin
               if (gather(value)) begin
                  if (size_acc > list_left) halt(rav_pkg::ST_DATA_SIZE);
                  else if (list_left == 0) close_entry(pos);
                  else phase = rav_pkg::PH_LIST_REST;
               end
            end
            rav_pkg::PH_LIST_REST: begin
               if (list_left == 0) close_entry(pos);
            end
            rav_pkg::PH_LIST_PAD: begin
               phase = rav_pkg::PH_LIST_ID;
            end
            default: begin
            end
         endcase
         if (phase >= rav_pkg::PH_PATH_ID && phase <= rav_pkg::PH_DATA_SIZE
             && list_left == 0) begin
            halt(rav_pkg::ST_LIST_SIZE);
         end
         if (pos == last_pos) begin
            if (first_error != rav_pkg::ST_OK) verdict.status = first_error;
            else if (phase == rav_pkg::PH_LIST_ID && field_index == 0)
               verdict.status = (entries_done != 0) ? rav_pkg::ST_OK : rav_pkg::ST_EMPTY;
            else verdict.status = rav_pkg::ST_INCOMPLETE;
            verdict.entry_count = entries_done;
            phase = rav_pkg::PH_IDLE;
            return 1'b1;
         end
         position = pos + 32'd1;
         return 1'b0;
      endfunction

      function void note_request(logic start, logic [7:0] value);
         rav_pkg::result_type verdict;
         if (take_byte(start, value, verdict)) begin
            verdicts.push_back(verdict);
         end
      endfunction

      function void flag(string text);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, text);
         end
      endfunction

      function void check_response(logic [rav_pkg::STATUS_WIDTH-1:0] got_status,
                                   logic [rav_pkg::COUNT_WIDTH-1:0] got_count);
         rav_pkg::result_type want;
         if (verdicts.size() == 0) begin
            flag($sformatf("unexpected response: status %0d, entry count %0d",
                           got_status, got_count));
            return;
         end
         want = verdicts.pop_front();
         if (got_status !== want.status) begin
            flag($sformatf("status mismatch: expected %0d, got %0d", want.status, got_status));
         end
         if (got_count !== want.entry_count) begin
            flag($sformatf("entry count mismatch: expected %0d, got %0d",
                           want.entry_count, got_count));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [rav_pkg::CSR_WIDTH-1:0] csr_write_data;
   bit idling = 1'b1;
   int requests_sent = 0;
   logic [7:0] image[$];
   int size_marks[$];
   int nul_marks[$];
   archive_scoreboard board = new();

   rav_req_if req_bus ();
   rav_rsp_if rsp_bus ();

   riff_archive_validator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("riff_archive_validator_test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_response(rsp_bus.status, rsp_bus.entry_count);
         end
         if (req_bus.valid && req_bus.ready) begin
            board.note_request(req_bus.start_req, req_bus.byte_in);
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic void put_tag(logic [31:0] tag);
      for (int k = 3; k >= 0; k--) image.push_back(tag[8 * k +: 8]);
   endfunction

   function automatic void put_word(logic [31:0] value);
      for (int k = 0; k < 4; k++) image.push_back(value[8 * k +: 8]);
   endfunction

   function automatic logic [31:0] word_at(int at);
      return {image[at + 3], image[at + 2], image[at + 1], image[at]};
   endfunction

   function automatic void poke_word(int at, logic [31:0] value);
      for (int k = 0; k < 4; k++) image[at + k] = value[8 * k +: 8];
   endfunction

   // Builds a well-formed archive; size fields and path terminators are
   // remembered so that they can be corrupted afterwards.
   function automatic void build_archive(int entries);
      int path_len;
      int data_len;
      int tail_len;
      int list_len;
      image.delete();
      size_marks.delete();
      nul_marks.delete();
      put_tag(rav_pkg::TAG_RIFF);
      size_marks.push_back(image.size());
      put_word(32'd0);
      put_tag(rav_pkg::TAG_FORM);
      for (int e = 0; e < entries; e++) begin
         path_len = $urandom_range(1, 6);
         data_len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 600)
                                                  : $urandom_range(0, 9);
         tail_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         list_len = 16 + path_len + path_len % 2 + data_len + tail_len;
         put_tag(rav_pkg::TAG_LIST);
         size_marks.push_back(image.size());
         put_word(list_len);
         put_tag(rav_pkg::TAG_PATH);
         size_marks.push_back(image.size());
         put_word(path_len);
         repeat (path_len - 1) image.push_back(8'($urandom));
         nul_marks.push_back(image.size());
         image.push_back(8'h00);
         if (path_len % 2) image.push_back(8'($urandom));
         put_tag(rav_pkg::TAG_DATA);
         size_marks.push_back(image.size());
         put_word(data_len);
         repeat (data_len + tail_len) image.push_back(8'($urandom));
         if (list_len % 2) image.push_back(8'($urandom));
      end
      poke_word(size_marks[0], image.size() - 8);
   endfunction

   task automatic send_byte(input logic start, input logic [7:0] value);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.start_req <= start;
      req_bus.byte_in <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_image(input logic start, input int lo, input int hi);
      for (int i = lo; i < hi; i++) send_byte(start && i == lo, image[i]);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_length(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_length(value);
   endtask

   task automatic run_image();
      write_length(image.size());
      send_image(1'b1, 0, image.size());
      settle();
   endtask

   task automatic stray_bytes();
      int held;
      held = requests_sent;
      repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom));
      settle();
      requests_sent = held;
   endtask

   initial begin
      int pick;
      int at;
      int keep;
      int split;
      logic [31:0] orig;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.start_req = 1'b0;
      req_bus.byte_in = 8'h00;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A byte without a start flag right after reset opens a buffer of length one.
      send_byte(1'b0, 8'hFF);
      settle();
      stray_bytes();
      write_length(32'd1);
      send_byte(1'b1, 8'h00);
      settle();
      build_archive(0);
      write_length(32'd11);
      send_image(1'b1, 0, 11);
      settle();
      run_image();
      build_archive(1);
      run_image();
      build_archive(3);
      run_image();

      build_archive(1);
      poke_word(size_marks[0], word_at(size_marks[0]) + 32'd1);
      run_image();
      build_archive(1);
      poke_word(size_marks[1], 32'd4);
      run_image();
      build_archive(1);
      poke_word(size_marks[1], word_at(size_marks[1]) + 32'h100);
      run_image();
      build_archive(1);
      poke_word(size_marks[2], 32'd0);
      run_image();
      build_archive(1);
      poke_word(size_marks[2], word_at(size_marks[1]) - 32'd7);
      run_image();
      build_archive(1);
      poke_word(size_marks[3], 32'hFFFF_FFFF);
      run_image();
      build_archive(1);
      image[nul_marks[0]] = 8'h5A;
      run_image();
      foreach (size_marks[k]) begin
         build_archive(1);
         at = (k == 0) ? 0 : size_marks[k] - 4;
         image[at] = image[at] ^ 8'h01;
         run_image();
      end
      build_archive(1);
      image[8] = image[8] ^ 8'h80;
      run_image();
      build_archive(2);
      repeat (5) void'(image.pop_back());
      run_image();

      // The length is changed in the middle of a buffer: first a zero length,
      // then the largest one.
      build_archive(1);
      write_length(32'd0);
      send_image(1'b1, 0, 5);
      settle();
      write_length(image.size());
      send_image(1'b0, 5, image.size());
      settle();
      build_archive(2);
      split = image.size() / 2;
      write_length(32'hFFFF_FFFF);
      send_image(1'b1, 0, split);
      settle();
      write_length(image.size());
      send_image(1'b0, split, image.size());
      settle();

      // A new start flag abandons a buffer that has not ended.
      build_archive(2);
      write_length(image.size());
      send_image(1'b1, 0, 15);
      settle();
      build_archive(1);
      run_image();

      requests_sent = 0;
      while (requests_sent < 500) begin
         idling = (requests_sent < 380) && ($urandom_range(0, 4) != 0);
         build_archive(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
         if ($urandom_range(0, 3) == 0) begin
            poke_word(size_marks[0], $urandom_range(0, image.size() - 8));
         end
         pick = $urandom_range(0, 99);
         if (pick < 13) begin
            at = $urandom_range(0, image.size() - 1);
            image[at] = image[at] ^ 8'($urandom_range(1, 255));
         end else if (pick < 27) begin
            at = size_marks[$urandom_range(0, size_marks.size() - 1)];
            orig = word_at(at);
            case ($urandom_range(0, 4))
               0: poke_word(at, 32'd0);
               1: poke_word(at, orig + 32'd1);
               2: poke_word(at, orig - 32'd1);
               3: poke_word(at, orig + $urandom_range(2, 64));
               default: poke_word(at, $urandom);
            endcase
         end else if (pick < 33 && nul_marks.size() != 0) begin
            image[nul_marks[$urandom_range(0, nul_marks.size() - 1)]] =
               8'($urandom_range(1, 255));
         end else if (pick < 41) begin
            keep = $urandom_range(1, image.size() - 1);
            while (image.size() > keep) void'(image.pop_back());
         end else if (pick < 45) begin
            repeat ($urandom_range(1, 12)) image.push_back(8'($urandom));
         end
         if (pick >= 90 && pick < 95) begin
            write_length(image.size());
            send_image(1'b1, 0, $urandom_range(1, image.size() - 1));
            settle();
         end else begin
            run_image();
            if (pick >= 95) stray_bytes();
         end
      end

      idling = 1'b0;
      settle();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.verdicts.size() == 0) begin
         $display("riff_archive_validator_test passed");
      end else begin
         $display("riff_archive_validator_test failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/rav_pkg.sv
rtl/core/rav_req_if.sv
rtl/core/rav_rsp_if.sv
rtl/core/rav_in_stage.sv
rtl/core/rav_parser.sv
rtl/core/rav_out_stage.sv
rtl/core/riff_archive_validator.sv
tb/riff_archive_validator_test.sv
